// ----- rtl/ddid_pkg.sv -----
`default_nettype none

package ddid_pkg;

   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 14;
   localparam int COUNT_W = 22;
   localparam int NUM_W   = 23;
   localparam int OFF_W   = 9;
   localparam int REM_W   = 7;
   localparam int YCMP_W  = 17;

   localparam int DATE_W       = DAY_W + MONTH_W + YEAR_W;
   localparam int REQ_FIELDS_W = 2 * DATE_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_DATA_W   = ((COUNT_W + 7) / 8) * 8;
   localparam int RSP_USER_W   = 1;

   localparam int MAX_YEAR_DEFAULT = 9999;
   localparam int YEAR_DIVISOR     = 100;
   localparam int DAYS_PER_YEAR    = 365;
   localparam int MONTHS           = 12;
   localparam int FEB_DAYS         = 28;
   localparam int FEB_LEAP_DAYS    = 29;

   // The year times 5243, shifted right by 19, equals the year divided by one hundred
   // for every year that fits in the year field.
   localparam int YEAR_RECIP       = 5243;
   localparam int YEAR_RECIP_W     = 13;
   localparam int YEAR_RECIP_SHIFT = 19;

   localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
   localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
   localparam logic [MONTH_W-1:0] MONTH_APR = MONTH_W'(4);
   localparam logic [MONTH_W-1:0] MONTH_JUN = MONTH_W'(6);
   localparam logic [MONTH_W-1:0] MONTH_SEP = MONTH_W'(9);
   localparam logic [MONTH_W-1:0] MONTH_NOV = MONTH_W'(11);

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic load;
      logic div_start;
      logic sel;
      logic mul_step;
      logic add_step;
      logic diff_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic div_done;
   } status_type;

   function automatic logic [OFF_W-1:0] month_start(input logic [MONTH_W-1:0] m);
      logic [OFF_W-1:0] r;
      unique case (m)
         4'd1:    r = OFF_W'(0);
         4'd2:    r = OFF_W'(31);
         4'd3:    r = OFF_W'(59);
         4'd4:    r = OFF_W'(90);
         4'd5:    r = OFF_W'(120);
         4'd6:    r = OFF_W'(151);
         4'd7:    r = OFF_W'(181);
         4'd8:    r = OFF_W'(212);
         4'd9:    r = OFF_W'(243);
         4'd10:   r = OFF_W'(273);
         4'd11:   r = OFF_W'(304);
         4'd12:   r = OFF_W'(334);
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
      logic [DAY_W-1:0] r;
      case (m) inside
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: r = DAY_W'(30);
         MONTH_FEB: r = leap ? DAY_W'(FEB_LEAP_DAYS) : DAY_W'(FEB_DAYS);
         default:   r = DAY_W'(31);
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/date_difference_in_days_unit.sv -----
`default_nettype none

// Channel   Direction  Signals                        Contents
// req       in         req_tvalid/tready/tdata        two dates, day/month/year each
// rsp       out        rsp_tvalid/tready/tdata/tuser  day count, dates valid flag
//
// A request occupies the block from acceptance until the next request can be taken:
// each date passes the start, divide, multiply and add states, the divide state
// dividing its year by one hundred, and then the difference and output load follow.
// The result waits in an output register, so a
// new request is taken while it is pending.
// Reset is synchronous and active high and clears the controller state and the divider.
// A stalled result holds the controller before it loads the next result.

module date_difference_in_days_unit #(
   parameter int unsigned MAX_YEAR = ddid_pkg::MAX_YEAR_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // first_day, first_month, first_year, second_day, second_month, second_year
   input  wire logic [ddid_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // day_count
   output logic      [ddid_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // dates_valid
   output logic      [ddid_pkg::RSP_USER_W-1:0]   rsp_tuser
);

   ddid_pkg::cmd_type    cmd;
   ddid_pkg::status_type status;

   ddid_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ddid_datapath #(
      .MAX_YEAR (MAX_YEAR)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   a_busy_after_request : assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("Block took a request while still busy.");

   a_invalid_count_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("Invalid dates gave a non-zero day count.");

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !rsp_tvalid || rsp_tready)
      else $error("Pending result overwritten.");

   a_divider_runs : assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> !status.div_done)
      else $error("Divider did not start.");

endmodule

`default_nettype wire

// ----- rtl/ddid_div.sv -----
`default_nettype none

module ddid_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [ddid_pkg::YEAR_W-1:0]   dividend,
   output logic                               done,
   output logic      [ddid_pkg::YEAR_W-1:0]   quotient,
   output logic      [ddid_pkg::REM_W-1:0]    remainder
);

   localparam int YW     = ddid_pkg::YEAR_W;
   localparam int RW     = ddid_pkg::REM_W;
   localparam int PROD_W = ddid_pkg::YEAR_W + ddid_pkg::YEAR_RECIP_W;

   logic              busy_ff, busy_in;
   logic [YW-1:0]     num_ff, num_in;
   logic [YW-1:0]     quo_ff, quo_in;
   logic [RW-1:0]     rem_ff, rem_in;
   logic [PROD_W-1:0] recip_prod;
   logic [YW-1:0]     rem_full;

   // The quotient comes from a reciprocal multiplication and is registered at start; the
   // remainder then comes from a multiply and subtract on the registered quotient.
   always_comb begin
      recip_prod = PROD_W'(dividend) * PROD_W'(ddid_pkg::YEAR_RECIP);
      rem_full   = num_ff - quo_ff * YW'(ddid_pkg::YEAR_DIVISOR);
      busy_in    = 1'b0;
      num_in     = num_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         num_in  = dividend;
         quo_in  = YW'(recip_prod >> ddid_pkg::YEAR_RECIP_SHIFT);
      end else if (busy_ff) begin
         rem_in = rem_full[RW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done      = !busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ----- rtl/ddid_datapath.sv -----
`default_nettype none

module ddid_datapath #(
   parameter int unsigned MAX_YEAR = ddid_pkg::MAX_YEAR_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire ddid_pkg::cmd_type                 cmd,
   output ddid_pkg::status_type                   status,
   input  wire logic [ddid_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic      [ddid_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic      [ddid_pkg::RSP_USER_W-1:0]   rsp_tuser
);

   localparam int DW = ddid_pkg::DAY_W;
   localparam int MW = ddid_pkg::MONTH_W;
   localparam int YW = ddid_pkg::YEAR_W;
   localparam int NW = ddid_pkg::NUM_W;
   localparam int OW = ddid_pkg::OFF_W;
   localparam int CW = ddid_pkg::COUNT_W;
   localparam int FW = ddid_pkg::DATE_W;

   logic [ddid_pkg::REQ_FIELDS_W-1:0] dates_ff;
   logic [FW-1:0]                      date_sel;
   logic [DW-1:0]                      d;
   logic [MW-1:0]                      m;
   logic [YW-1:0]                      y;
   logic [YW-1:0]                      q;
   logic [ddid_pkg::REM_W-1:0]         r;
   logic                               div_done;
   logic                               r_nz;
   logic                               leap;
   logic                               ok;
   logic [YW-1:0]                      ceil4, ceil100, ceil400;
   logic [NW-1:0]                      prod_ff;
   logic [YW-1:0]                      corr_ff;
   logic [OW-1:0]                      off_ff;
   logic [1:0]                         valid_ff;
   logic [NW-1:0]                      num0_ff, num1_ff;
   logic [NW-1:0]                      num_sum;
   logic [NW-1:0]                      diff_ff;
   logic [CW-1:0]                      count_ff;
   logic                               flag_ff;
   logic                               both_ok;

   assign date_sel = cmd.sel ? dates_ff[2*FW-1:FW] : dates_ff[FW-1:0];
   assign d        = date_sel[DW-1:0];
   assign m        = date_sel[DW+MW-1:DW];
   assign y        = date_sel[FW-1:DW+MW];

   ddid_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (y),
      .done      (div_done),
      .quotient  (q),
      .remainder (r)
   );

   assign status.div_done = div_done;

   always_comb begin
      r_nz    = (r != '0);
      leap    = ((y[1:0] == 2'b00) && r_nz) || (!r_nz && (q[1:0] == 2'b00));
      ok      = ({(ddid_pkg::YCMP_W - YW)'(0), y} <= ddid_pkg::YCMP_W'(MAX_YEAR))
                && (m >= ddid_pkg::MONTH_JAN) && (m <= MW'(ddid_pkg::MONTHS))
                && (d != '0) && (d <= ddid_pkg::month_len(m, leap));
      ceil4   = (y >> 2) + YW'(y[1:0] != 2'b00);
      ceil100 = q + YW'(r_nz);
      ceil400 = (q >> 2) + YW'(r_nz || (q[1:0] != 2'b00));
      num_sum = prod_ff + NW'(corr_ff) + NW'(off_ff);
      both_ok = valid_ff[0] && valid_ff[1];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         dates_ff <= req_tdata[ddid_pkg::REQ_FIELDS_W-1:0];
      end
      if (cmd.mul_step) begin
         prod_ff            <= NW'(y) * NW'(ddid_pkg::DAYS_PER_YEAR);
         corr_ff            <= ceil4 - ceil100 + ceil400;
         off_ff             <= ddid_pkg::month_start(m)
                               + OW'((m > ddid_pkg::MONTH_FEB) && leap)
                               + OW'(d) - OW'(1);
         valid_ff[cmd.sel]  <= ok;
      end
      if (cmd.add_step) begin
         if (cmd.sel) begin
            num1_ff <= num_sum;
         end else begin
            num0_ff <= num_sum;
         end
      end
      if (cmd.diff_step) begin
         diff_ff <= (num0_ff >= num1_ff) ? (num0_ff - num1_ff) : (num1_ff - num0_ff);
      end
      if (cmd.out_load) begin
         flag_ff <= both_ok;
         if (!both_ok) begin
            count_ff <= '0;
         end else if (diff_ff > NW'(ddid_pkg::COUNT_MAX)) begin
            count_ff <= ddid_pkg::COUNT_MAX;
         end else begin
            count_ff <= diff_ff[CW-1:0];
         end
      end
   end

   assign rsp_tdata = {(ddid_pkg::RSP_DATA_W - CW)'(0), count_ff};
   assign rsp_tuser = ddid_pkg::RSP_USER_W'(flag_ff);

endmodule

`default_nettype wire

// ----- rtl/ddid_ctrl.sv -----
`default_nettype none

module ddid_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   input  wire ddid_pkg::status_type   status,
   output ddid_pkg::cmd_type           cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_START,
      S_DIV,
      S_MUL,
      S_ADD,
      S_DIFF,
      S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      sel_ff, sel_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      sel_in       = sel_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      cmd.sel      = sel_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               sel_in   = 1'b0;
               state_in = S_START;
            end
         end
         S_START: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (status.div_done) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul_step = 1'b1;
            state_in     = S_ADD;
         end
         S_ADD: begin
            cmd.add_step = 1'b1;
            if (!sel_ff) begin
               sel_in   = 1'b1;
               state_in = S_START;
            end else begin
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            cmd.diff_step = 1'b1;
            state_in      = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sel_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire
